>>> hw/rtl/wat_pkg.sv
package wat_pkg;

  localparam int unsigned AddrWidth   = 16;
  localparam int unsigned OffsetWidth = 10;
  localparam int unsigned ValueWidth  = 5;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_TRACE = 2'd1,
    WR_DPRAM = 2'd2
  } win_write_t;

  // device-side region bounds, upper bound exclusive
  localparam logic [AddrWidth-1:0] REG0_END   = 16'h0040;
  localparam logic [AddrWidth-1:0] REG1_BEGIN = 16'h00f0;
  localparam logic [AddrWidth-1:0] REG1_END   = 16'h0100;
  localparam logic [AddrWidth-1:0] REG2_BEGIN = 16'h1000;
  localparam logic [AddrWidth-1:0] REG2_END   = 16'h1010;
  localparam logic [AddrWidth-1:0] REG3_BEGIN = 16'h2000;
  localparam logic [AddrWidth-1:0] REG3_END   = 16'h203c;
  localparam logic [AddrWidth-1:0] REG4_BEGIN = 16'hc000;
  localparam logic [AddrWidth-1:0] REG4_END   = 16'hc030;
  localparam logic [AddrWidth-1:0] TRACE_BEGIN = 16'h0100;
  localparam logic [AddrWidth-1:0] TRACE_END   = 16'h0300;
  localparam logic [AddrWidth-1:0] DPRAM_BEGIN = 16'he000;
  localparam logic [AddrWidth-1:0] DPRAM_END   = 16'he800;

  // bus offsets, already relative to the mapped base
  localparam logic [OffsetWidth-1:0] OFS_REG0  = 10'h020;
  localparam logic [OffsetWidth-1:0] OFS_REG1  = 10'h060;
  localparam logic [OffsetWidth-1:0] OFS_REG2  = 10'h070;
  localparam logic [OffsetWidth-1:0] OFS_REG3  = 10'h080;
  localparam logic [OffsetWidth-1:0] OFS_REG4  = 10'h0c0;
  localparam logic [OffsetWidth-1:0] OFS_TRACE = 10'h1f0;
  localparam logic [OffsetWidth-1:0] OFS_DPRAM = 10'h200;

  typedef struct packed {
    logic [4:0] trace_window;
    logic       trace_known;
    logic [1:0] dpram_window;
    logic       dpram_known;
  } win_state_t;

  typedef struct packed {
    logic [OffsetWidth-1:0] bus_offset;
    win_write_t             window_write;
    logic [ValueWidth-1:0]  window_value;
    logic                   addr_error;
  } result_t;

endpackage

>>> hw/rtl/wat_addr_if.sv
interface wat_addr_if;
  logic                           valid;
  logic                           ready;
  logic [wat_pkg::AddrWidth-1:0]  device_addr;

  modport source (output valid, output device_addr, input ready);
  modport sink (input valid, input device_addr, output ready);
endinterface

>>> hw/rtl/wat_result_if.sv
interface wat_result_if;
  logic                            valid;
  logic                            ready;
  logic [wat_pkg::OffsetWidth-1:0] bus_offset;
  logic [1:0]                      window_write;
  logic [wat_pkg::ValueWidth-1:0]  window_value;
  logic                            addr_error;

  modport source (
    output valid, output bus_offset, output window_write, output window_value,
    output addr_error, input ready
  );
  modport sink (
    input valid, input bus_offset, input window_write, input window_value,
    input addr_error, output ready
  );
endinterface

>>> hw/rtl/wat_decode.sv
module wat_decode (
  input  logic [wat_pkg::AddrWidth-1:0] addr,
  input  wat_pkg::win_state_t           st,
  output wat_pkg::result_t              res,
  output wat_pkg::win_state_t           st_next
);

  logic [4:0] trace_w;
  logic [1:0] dpram_w;

  assign trace_w = addr[8:4];
  assign dpram_w = addr[10:9];

  always_comb begin
    res          = '0;
    res.window_write = wat_pkg::WR_NONE;
    st_next      = st;
    priority if (addr < wat_pkg::REG0_END) begin
      res.bus_offset = {4'd0, addr[5:0]} + wat_pkg::OFS_REG0;
    end else if (addr >= wat_pkg::REG1_BEGIN && addr < wat_pkg::REG1_END) begin
      res.bus_offset = {6'd0, addr[3:0]} + wat_pkg::OFS_REG1;
    end else if (addr >= wat_pkg::REG2_BEGIN && addr < wat_pkg::REG2_END) begin
      res.bus_offset = {6'd0, addr[3:0]} + wat_pkg::OFS_REG2;
    end else if (addr >= wat_pkg::REG3_BEGIN && addr < wat_pkg::REG3_END) begin
      res.bus_offset = {4'd0, addr[5:0]} + wat_pkg::OFS_REG3;
    end else if (addr >= wat_pkg::REG4_BEGIN && addr < wat_pkg::REG4_END) begin
      res.bus_offset = {4'd0, addr[5:0]} + wat_pkg::OFS_REG4;
    end else if (addr >= wat_pkg::TRACE_BEGIN && addr < wat_pkg::TRACE_END) begin
      res.bus_offset = {6'd0, addr[3:0]} + wat_pkg::OFS_TRACE;
      if (!st.trace_known || trace_w != st.trace_window) begin
        res.window_write     = wat_pkg::WR_TRACE;
        res.window_value     = trace_w;
        st_next.trace_window = trace_w;
        st_next.trace_known  = 1'b1;
      end
    end else if (addr >= wat_pkg::DPRAM_BEGIN && addr < wat_pkg::DPRAM_END) begin
      res.bus_offset = {1'b0, addr[8:0]} + wat_pkg::OFS_DPRAM;
      if (!st.dpram_known || dpram_w != st.dpram_window) begin
        res.window_write     = wat_pkg::WR_DPRAM;
        res.window_value     = {3'd0, dpram_w};
        st_next.dpram_window = dpram_w;
        st_next.dpram_known  = 1'b1;
      end
    end else begin
      res.addr_error = 1'b1;
    end
  end

endmodule

>>> hw/rtl/windowed_address_translator_core.sv
// channel  dir  payload                                              handshake
// req      in   device_addr[15:0]                                    valid/ready
// rsp      out  bus_offset[9:0] window_write[1:0] window_value[4:0]  valid/ready
//               addr_error
// Path: req is captured in the input register, decoded, and held in the result register that drives rsp.
// Throughput: one item per cycle while rsp is not stalled; the decode between the two registers sets it.
// Window state updates as an item moves from the input to the result register.
// rst clears both valid bits and forgets both stored windows.
// A stalled rsp holds the result; req keeps flowing until the input register fills.
module windowed_address_translator_core (
  input  logic               clk,
  input  logic               rst,
  wat_addr_if.sink           req,
  wat_result_if.source       rsp
);

  logic                          in_valid;
  logic [wat_pkg::AddrWidth-1:0] in_addr;
  logic                          out_valid;
  wat_pkg::result_t              out_res;
  wat_pkg::win_state_t           win_state;
  wat_pkg::win_state_t           win_state_next;
  wat_pkg::result_t              dec_res;
  logic                          advance;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  wat_decode u_decode (
    .addr    (in_addr),
    .st      (win_state),
    .res     (dec_res),
    .st_next (win_state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_addr <= req.device_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      win_state <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        win_state <= win_state_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= dec_res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.bus_offset   = out_res.bus_offset;
  assign rsp.window_write = out_res.window_write;
  assign rsp.window_value = out_res.window_value;
  assign rsp.addr_error   = out_res.addr_error;

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.addr_error |->
      out_res.bus_offset == '0 && out_res.window_write == wat_pkg::WR_NONE &&
      out_res.window_value == '0)
    else $error("error result carries payload");

  a_value_only_on_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.window_write == wat_pkg::WR_NONE |-> out_res.window_value == '0)
    else $error("window value without window write");

  a_trace_known_sticky: assert property (@(posedge clk) disable iff (rst)
    win_state.trace_known |=> win_state.trace_known)
    else $error("trace window forgotten");

  a_trace_write_tracks: assert property (@(posedge clk) disable iff (rst)
    advance && dec_res.window_write == wat_pkg::WR_TRACE |=>
      win_state.trace_window == out_res.window_value && win_state.trace_known)
    else $error("trace window state differs from written value");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_addr))
    else $error("stalled input register changed");

endmodule
